// ===== hw/rtl/http_chunked_body_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Shared property wrappers used by the checker of the decoder core.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HCBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcbd check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcbd check failed: next-cycle rule");

`endif

// ===== hw/rtl/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types and constants shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbd_pkg;

   localparam int BYTE_WIDTH     = 8;
   localparam int CHUNK_WIDTH    = 64;
   localparam int MAX_SIZE_WIDTH = 32;
   localparam int HEX_RADIX_BITS = 4;

   localparam logic [BYTE_WIDTH-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CHAR_TAB   = 8'h09;

   typedef enum logic [1:0] {
      FUNC_BYTE    = 2'd0,
      FUNC_EOS     = 2'd1,
      FUNC_RESTART = 2'd2
   } hcbd_func_type;

   typedef enum logic [2:0] {
      ST_RUN      = 3'd0,
      ST_COMPLETE = 3'd1,
      ST_MALFORM  = 3'd2,
      ST_TOOBIG   = 3'd3,
      ST_EOF      = 3'd4
   } hcbd_status_type;

   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,
      PH_DIGITS = 3'd1,
      PH_REST   = 3'd2,
      PH_BAD    = 3'd3,
      PH_DATA   = 3'd4,
      PH_TR1    = 3'd5,
      PH_TR2    = 3'd6,
      PH_DONE   = 3'd7
   } hcbd_phase_type;

   typedef struct packed {
      hcbd_phase_type         phase;
      hcbd_status_type        final_status;
      logic                   cr_pending;
      logic                   digits_seen;
      logic [CHUNK_WIDTH-1:0] chunk_length;
      logic [CHUNK_WIDTH-1:0] chunk_remaining;
   } hcbd_state_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] out_byte;
      logic                  out_valid;
      hcbd_status_type       status;
   } hcbd_rsp_type;

endpackage

// ===== hw/rtl/hcbd_intf.sv =====
// ----------------------------------------------------------------------------
// hcbd_req_if / hcbd_rsp_if
// Valid/ready channels carrying decoder requests and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface hcbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic [2:0] status;

   modport source (output valid, output out_byte, output out_valid, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input out_valid, input status,
                   output ready);
endinterface

// ===== hw/rtl/hcbd_step.sv =====
// ----------------------------------------------------------------------------
// hcbd_step
// Next-state and response logic for one request of the chunked decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbd_step
   import hcbd_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic [1:0]                func,
   input  logic [BYTE_WIDTH-1:0]     data_byte,
   input  logic [MAX_SIZE_WIDTH-1:0] max_size,
   input  hcbd_state_type            cur,
   input  logic [COUNT_WIDTH-1:0]    cur_count,
   output hcbd_state_type            nxt,
   output logic [COUNT_WIDTH-1:0]    nxt_count,
   output hcbd_rsp_type              rsp
);

   localparam int CMP_W = (COUNT_WIDTH > MAX_SIZE_WIDTH) ? COUNT_WIDTH : MAX_SIZE_WIDTH;

   logic                      is_hex;
   logic [HEX_RADIX_BITS-1:0] hex_val;
   logic                      is_space;
   logic                      too_big;
   logic [COUNT_WIDTH-1:0]    count_inc;
   logic [CMP_W-1:0]          count_ext;
   logic [CMP_W-1:0]          max_ext;

   always_comb begin
      is_hex  = 1'b1;
      hex_val = '0;
      if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
         hex_val = HEX_RADIX_BITS'(data_byte - 8'h30);
      end else if (data_byte >= 8'h61 && data_byte <= 8'h66) begin
         hex_val = HEX_RADIX_BITS'(data_byte - 8'h57);
      end else if (data_byte >= 8'h41 && data_byte <= 8'h46) begin
         hex_val = HEX_RADIX_BITS'(data_byte - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign is_space  = (data_byte == CHAR_SPACE) ||
                      (data_byte >= CHAR_TAB && data_byte <= CHAR_CR);
   assign count_ext = CMP_W'(cur_count);
   assign max_ext   = CMP_W'(max_size);
   assign too_big   = (max_size != '0) && (count_ext > max_ext);
   // The consumed byte counter saturates at all ones.
   assign count_inc = (&cur_count) ? cur_count : cur_count + 1'b1;

   // Next state.
   always_comb begin
      nxt       = cur;
      nxt_count = cur_count;
      unique case (func)
         FUNC_RESTART: begin
            nxt.phase           = PH_LEAD;
            nxt.final_status    = ST_RUN;
            nxt.cr_pending      = 1'b0;
            nxt.digits_seen     = 1'b0;
            nxt.chunk_length    = '0;
            nxt.chunk_remaining = '0;
            nxt_count           = '0;
         end
         FUNC_EOS: begin
            if (cur.phase != PH_DONE) begin
               nxt.phase        = PH_DONE;
               nxt.final_status = (cur.phase == PH_DATA) ? ST_EOF : ST_COMPLETE;
            end
         end
         FUNC_BYTE: begin
            unique case (cur.phase)
               PH_DATA: begin
                  if (too_big) begin
                     nxt.phase        = PH_DONE;
                     nxt.final_status = ST_TOOBIG;
                  end else begin
                     nxt_count           = count_inc;
                     nxt.chunk_remaining = cur.chunk_remaining - 1'b1;
                     if (cur.chunk_remaining == CHUNK_WIDTH'(1)) begin
                        nxt.phase = PH_TR1;
                     end
                  end
               end
               PH_TR1: begin
                  nxt_count = count_inc;
                  nxt.phase = PH_TR2;
               end
               PH_TR2: begin
                  nxt_count        = count_inc;
                  nxt.phase        = PH_LEAD;
                  nxt.cr_pending   = 1'b0;
                  nxt.digits_seen  = 1'b0;
                  nxt.chunk_length = '0;
               end
               PH_DONE: begin
               end
               PH_LEAD, PH_DIGITS, PH_REST, PH_BAD: begin
                  nxt_count = count_inc;
                  if (cur.cr_pending && data_byte == CHAR_LF) begin
                     // A CR LF pair closes the size line.
                     nxt.cr_pending = 1'b0;
                     if (cur.phase == PH_BAD || !cur.digits_seen) begin
                        nxt.phase        = PH_DONE;
                        nxt.final_status = ST_MALFORM;
                     end else if (cur.chunk_length == '0) begin
                        nxt.phase        = PH_DONE;
                        nxt.final_status = ST_COMPLETE;
                     end else begin
                        nxt.chunk_remaining = cur.chunk_length;
                        nxt.phase           = PH_DATA;
                     end
                  end else begin
                     nxt.cr_pending = (data_byte == CHAR_CR);
                     if (cur.phase == PH_LEAD) begin
                        if (is_hex) begin
                           nxt.digits_seen  = 1'b1;
                           nxt.chunk_length = CHUNK_WIDTH'(hex_val);
                           nxt.phase        = PH_DIGITS;
                        end else if (!is_space) begin
                           nxt.phase = PH_REST;
                        end
                     end else if (cur.phase == PH_DIGITS) begin
                        if (!is_hex) begin
                           nxt.phase = PH_REST;
                        end else if (cur.chunk_length[CHUNK_WIDTH-1 -: HEX_RADIX_BITS]
                                     != '0) begin
                           nxt.phase = PH_BAD;
                        end else begin
                           nxt.chunk_length = {cur.chunk_length[CHUNK_WIDTH-HEX_RADIX_BITS-1:0],
                                               hex_val};
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Response fields.
   always_comb begin
      rsp.out_valid = (func == FUNC_BYTE) && (cur.phase == PH_DATA) && !too_big;
      rsp.out_byte  = rsp.out_valid ? data_byte : '0;
      rsp.status    = nxt.final_status;
   end

endmodule

// ===== hw/rtl/hcbd_rsp_stage.sv =====
// ----------------------------------------------------------------------------
// hcbd_rsp_stage
// Response register between the decoder logic and the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbd_rsp_stage
   import hcbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  hcbd_rsp_type rsp_in,
   input  logic         take,
   output logic         can_load,
   output logic         rsp_valid,
   output hcbd_rsp_type rsp_out
);

   logic         valid_ff;
   logic         valid_in;
   hcbd_rsp_type data_ff;

   assign can_load = !valid_ff || take;
   assign valid_in = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = data_ff;

endmodule

// ===== hw/rtl/http_chunked_body_decoder_core.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// A response is registered; it appears in the cycle after its request is accepted.
// Throughput: one request per cycle while rsp_bus is ready; the response
// register refills while its current response is taken, so no bubble is inserted.
// Reset: synchronous, active high; clears the parse state, the byte counter,
// the size limit register and the response valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Decodes an HTTP/1.1 chunked body one byte per request. The parse state,
// the chunk size being read, the bytes left in the current chunk and a
// saturating count of consumed bytes live in registers here. All of the
// work for one request is done by the combinational step logic, and the
// result is captured in a single response register. A request is taken
// whenever that register is empty or is being drained in the same cycle.
module http_chunked_body_decoder_core
   import hcbd_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   hcbd_req_if.sink                  req_bus,
   hcbd_rsp_if.source                rsp_bus,
   input  logic                      csr_write_en,
   input  logic [MAX_SIZE_WIDTH-1:0] csr_write_data
);

   // Size limit register; zero disables the limit.
   logic [MAX_SIZE_WIDTH-1:0] max_size_ff;

   hcbd_state_type            state_ff;
   hcbd_state_type            state_in;
   logic [COUNT_WIDTH-1:0]    count_ff;
   logic [COUNT_WIDTH-1:0]    count_in;
   hcbd_rsp_type              step_rsp;
   hcbd_rsp_type              stage_rsp;
   logic                      can_load;
   logic                      accept;
   logic                      stage_valid;

   assign req_bus.ready = can_load;
   assign accept        = req_bus.valid && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= '0;
      end else if (csr_write_en) begin
         max_size_ff <= csr_write_data;
      end
   end

   // The step logic sees the state left by the previous request and
   // produces both the next state and this request's response.
   hcbd_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .func      (req_bus.func),
      .data_byte (req_bus.data_byte),
      .max_size  (max_size_ff),
      .cur       (state_ff),
      .cur_count (count_ff),
      .nxt       (state_in),
      .nxt_count (count_in),
      .rsp       (step_rsp)
   );

   // The parse state only advances on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= PH_LEAD;
         state_ff.final_status    <= ST_RUN;
         state_ff.cr_pending      <= 1'b0;
         state_ff.digits_seen     <= 1'b0;
         state_ff.chunk_length    <= '0;
         state_ff.chunk_remaining <= '0;
         count_ff                 <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   hcbd_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .rsp_in    (step_rsp),
      .take      (rsp_bus.ready),
      .can_load  (can_load),
      .rsp_valid (stage_valid),
      .rsp_out   (stage_rsp)
   );

   assign rsp_bus.valid     = stage_valid;
   assign rsp_bus.out_byte  = stage_rsp.out_byte;
   assign rsp_bus.out_valid = stage_rsp.out_valid;
   assign rsp_bus.status    = stage_rsp.status;

endmodule

// ===== hw/rtl/hcbd_checker.sv =====
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks for the chunked body decoder, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "http_chunked_body_decoder_core_macros.svh"

module hcbd_checker
   import hcbd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_valid,
   input logic [2:0] rsp_status
);

   // A stalled response keeps its contents.
   `HCBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_valid) && $stable(rsp_status))

   // With the response register empty, a request is always taken.
   `HCBD_ASSERT_NOW(a_no_bubble, clock, reset, !rsp_valid, req_ready)

   // A payload byte is only passed while the body is still running.
   `HCBD_ASSERT_NOW(a_byte_running, clock, reset, rsp_valid && rsp_out_valid,
      rsp_status == ST_RUN)

   // Without a payload byte the byte field reads zero.
   `HCBD_ASSERT_NOW(a_byte_zero, clock, reset, rsp_valid && !rsp_out_valid,
      rsp_out_byte == 8'h00)

   // An accepted request always yields a response in the next cycle.
   `HCBD_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid)

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_out_byte  (rsp_bus.out_byte),
   .rsp_out_valid (rsp_bus.out_valid),
   .rsp_status    (rsp_bus.status)
);
